/* src/bcdux_pkg.sv */
// ----------------------------------------------------------------------------
// bcdux_pkg
// Shared types, constants and helper functions for the BCD date to
// Unix seconds converter.
// ----------------------------------------------------------------------------
package bcdux_pkg;

	localparam int unsigned DaysW  = 17;	// day count up to about 71.6k
	localparam int unsigned TodW   = 18;	// time of day up to 167185 s
	localparam int unsigned SecsW  = 33;

	// Days from 1970-01-01 to 2000-01-01
	localparam logic [DaysW-1:0] EpochToBaseDays = 17'd10957;
	localparam logic [SecsW-1:0] SecsPerDay      = 33'd86400;
	localparam logic [TodW-1:0]  SecsPerHour     = 18'd3600;
	localparam logic [TodW-1:0]  SecsPerMin      = 18'd60;
	localparam logic [7:0]       NoLeapYear      = 8'd100;	// 2100
	localparam logic [7:0]       FirstAfterNoLeap = 8'd101;
	localparam logic [3:0]       LastMonth       = 4'd12;

	typedef struct packed {
		logic [6:0] sec;	// 0..85
		logic [6:0] min;	// 0..85
		logic [5:0] hr;		// 0..45
		logic [5:0] day;	// 0..45
		logic [3:0] mon;	// 0..12 after saturation
		logic [7:0] yy;		// 0..165
	} dec_t;

	// tens*10 + units, nibbles above 9 taken as they are
	function automatic logic [7:0] bcd_dec(input logic [7:0] b);
		logic [7:0] tens;
		tens = {4'd0, b[7:4]};
		return (tens << 3) + (tens << 1) + {4'd0, b[3:0]};
	endfunction

	// Days before the first of the month in a common year; month 0 adds none
	function automatic logic [8:0] cum_days(input logic [3:0] mon);
		logic [8:0] d;
		unique case (mon)
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

/* src/bcdux_decode.sv */
// ----------------------------------------------------------------------------
// bcdux_decode
// Stage 1: masks the raw clock bytes, decodes BCD and saturates the month.
// ----------------------------------------------------------------------------
module bcdux_decode import bcdux_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  logic [7:0] seconds_bcd,
	input  logic [7:0] minutes_bcd,
	input  logic [7:0] hours_bcd,
	input  logic [7:0] date_bcd,
	input  logic [7:0] month_bcd,
	input  logic [7:0] year_bcd,
	output dec_t       dec_s1
);

	logic [7:0] sec_d, min_d, hr_d, day_d, mon_d, yy_d;
	logic [3:0] mon_sat;
	dec_t       dec_d;

	always_comb begin
		sec_d = bcd_dec(seconds_bcd & 8'h7F);
		min_d = bcd_dec(minutes_bcd & 8'h7F);
		hr_d  = bcd_dec(hours_bcd & 8'h3F);
		day_d = bcd_dec(date_bcd & 8'h3F);
		mon_d = bcd_dec(month_bcd & 8'h1F);
		yy_d  = bcd_dec(year_bcd);
		// months past December count as December
		mon_sat = (mon_d > {4'd0, LastMonth}) ? LastMonth : mon_d[3:0];
		dec_d.sec = sec_d[6:0];
		dec_d.min = min_d[6:0];
		dec_d.hr  = hr_d[5:0];
		dec_d.day = day_d[5:0];
		dec_d.mon = mon_sat;
		dec_d.yy  = yy_d;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_s1 <= dec_d;
		end
	end

endmodule

/* src/bcdux_days.sv */
// ----------------------------------------------------------------------------
// bcdux_days
// Stage 2: day count since the epoch and seconds into the day.
// ----------------------------------------------------------------------------
module bcdux_days import bcdux_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  dec_t             dec_s1,
	output logic [DaysW-1:0] days_s2,
	output logic [TodW-1:0]  tod_s2
);

	logic [8:0]       yy_p3;
	logic [5:0]       leaps;
	logic             leap_fix;
	logic [DaysW-1:0] year_days;
	logic [DaysW-1:0] days_d;
	logic [TodW-1:0]  tod_d;

	always_comb begin
		// leap years 2000 .. year-1: multiples of four, less 2100 once passed
		yy_p3 = {1'b0, dec_s1.yy} + 9'd3;
		leaps = yy_p3[7:2] - {5'd0, (dec_s1.yy >= FirstAfterNoLeap)};
		leap_fix = (dec_s1.mon > 4'd2) && (dec_s1.yy[1:0] == 2'd0)
			&& (dec_s1.yy != NoLeapYear);
		year_days = EpochToBaseDays + {9'd0, dec_s1.yy} * 17'd365
			+ {11'd0, leaps};
		// date zero lands on the day before the first
		days_d = year_days + {8'd0, cum_days(dec_s1.mon)} + {16'd0, leap_fix}
			+ {11'd0, dec_s1.day} - 17'd1;
		tod_d = {12'd0, dec_s1.hr} * SecsPerHour + {11'd0, dec_s1.min} * SecsPerMin
			+ {11'd0, dec_s1.sec};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			days_s2 <= days_d;
			tod_s2  <= tod_d;
		end
	end

endmodule

/* src/bcdux_secs.sv */
// ----------------------------------------------------------------------------
// bcdux_secs
// Stages 3 and 4: day count times 86400, then the time of day added.
// ----------------------------------------------------------------------------
module bcdux_secs import bcdux_pkg::*; (
	input  logic             clk,
	input  logic             en3,
	input  logic             en4,
	input  logic [DaysW-1:0] days_s2,
	input  logic [TodW-1:0]  tod_s2,
	output logic [SecsW-1:0] secs_s4
);

	logic [SecsW-1:0] prod_s3;
	logic [TodW-1:0]  tod_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			prod_s3 <= {16'd0, days_s2} * SecsPerDay;
			tod_s3  <= tod_s2;
		end
		if (en4) begin
			secs_s4 <= prod_s3 + {15'd0, tod_s3};
		end
	end

endmodule

/* src/bcd_date_to_unix_seconds_core.sv */
// ----------------------------------------------------------------------------
// bcd_date_to_unix_seconds_core
// Converts raw BCD clock bytes (seconds .. two-digit year of the 2000s)
// into seconds since 1970-01-01 00:00:00.
//
// Input channel: in_valid / in_stall with the six BCD bytes. An item is
// taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with unix_seconds, one result
// per item, in order.
// Four register stages: decode, day count and time of day, multiply by
// 86400, final add. An accepted item passes through them in that order, and
// out_valid is the valid bit of the final-add stage; one item
// per cycle is sustained while the output is not stalled.
// Each stage holds its item when the stage after it is full and stalled, so
// bubbles close up under a stall and in_stall rises only once all four
// stages are full and out_stall is high. Nothing is lost or repeated.
// Reset (arst_n low) empties the pipeline; payload registers are not reset.
// There are no configuration registers.
// ----------------------------------------------------------------------------
module bcd_date_to_unix_seconds_core import bcdux_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  seconds_bcd,
	input  logic [7:0]  minutes_bcd,
	input  logic [7:0]  hours_bcd,
	input  logic [7:0]  date_bcd,
	input  logic [7:0]  month_bcd,
	input  logic [7:0]  year_bcd,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [32:0] unix_seconds
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic en1, en2, en3, en4;
	dec_t             dec_s1;
	logic [DaysW-1:0] days_s2;
	logic [TodW-1:0]  tod_s2;
	logic [SecsW-1:0] secs_s4;

	always_comb begin
		rdy4 = !v_s4 || !out_stall;
		rdy3 = !v_s3 || rdy4;
		rdy2 = !v_s2 || rdy3;
		rdy1 = !v_s1 || rdy2;
		en1  = in_valid && rdy1;
		en2  = v_s1 && rdy2;
		en3  = v_s2 && rdy3;
		en4  = v_s3 && rdy4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	bcdux_decode u_decode (
		.clk         (clk),
		.en          (en1),
		.seconds_bcd (seconds_bcd),
		.minutes_bcd (minutes_bcd),
		.hours_bcd   (hours_bcd),
		.date_bcd    (date_bcd),
		.month_bcd   (month_bcd),
		.year_bcd    (year_bcd),
		.dec_s1      (dec_s1)
	);

	bcdux_days u_days (
		.clk     (clk),
		.en      (en2),
		.dec_s1  (dec_s1),
		.days_s2 (days_s2),
		.tod_s2  (tod_s2)
	);

	bcdux_secs u_secs (
		.clk     (clk),
		.en3     (en3),
		.en4     (en4),
		.days_s2 (days_s2),
		.tod_s2  (tod_s2),
		.secs_s4 (secs_s4)
	);

	assign in_stall     = !rdy1;
	assign out_valid    = v_s4;
	assign unix_seconds = secs_s4;

	// input backs up only with every stage full and the output stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && out_stall))
		else $error("input stalled with room in the pipeline");

	// a delivered result with nothing behind it leaves the last stage empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !out_stall && !v_s3) |=> !v_s4)
		else $error("result repeated at output");

	// an item in stage 3 moves on or stays, never vanishes
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |=> (v_s3 || v_s4))
		else $error("item lost between stages 3 and 4");

	// an accepted item always lands in stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted item not captured");

endmodule

/* sim/bcd_date_to_unix_seconds_core_tb.sv */
// ----------------------------------------------------------------------------
// bcd_date_to_unix_seconds_core_tb
// Self-checking bench for the BCD clock to Unix seconds converter. Drives
// directed corner dates and then random bursts of BCD clock bytes, with a
// randomly stalling receiver. Every accepted item is converted by a
// scoreboard and compared in order against the results.
// ----------------------------------------------------------------------------
module bcd_date_to_unix_seconds_core_tb import bcdux_pkg::*;;

	localparam int unsigned CycleLimit  = 200000;
	localparam int unsigned RandomItems = 1400;
	localparam int unsigned HoldCycles  = 60;

	class date_scoreboard;
		logic [SecsW-1:0] pending_secs[$];
		int unsigned      errors;
		int unsigned      month_start[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243,
			273, 304, 334};

		function new();
			errors = 0;
		endfunction

		// tens*10 + units; nibbles above 9 are taken as they are
		static function int unsigned bcd_value(bit [7:0] b);
			return int'(b[7:4]) * 10 + int'(b[3:0]);
		endfunction

		static function int unsigned leap_years_upto(int unsigned n);
			return n / 4 - n / 100 + n / 400;
		endfunction

		function logic [SecsW-1:0] expected_secs(bit [7:0] s, bit [7:0] m, bit [7:0] h,
				bit [7:0] d, bit [7:0] mo, bit [7:0] y);
			int unsigned      secs, mins, hrs, mday, mon, year;
			bit               leap;
			longint unsigned  days;
			longint unsigned  total;
			secs = bcd_value(s & 8'h7F);
			mins = bcd_value(m & 8'h7F);
			hrs  = bcd_value(h & 8'h3F);
			mday = bcd_value(d & 8'h3F);
			mon  = bcd_value(mo & 8'h1F);
			year = bcd_value(y) + 2000;
			if (mon > 12)
				mon = 12;
			days = 365 * (year - 1970) + leap_years_upto(year - 1) - leap_years_upto(1969);
			leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
			if (mon >= 1) begin
				days += month_start[mon - 1];
				if (mon > 2 && leap)
					days += 1;
			end
			// date zero lands on the day before the first
			days  = days + mday - 1;
			total = days * 86400 + hrs * 3600 + mins * 60 + secs;
			return total[SecsW-1:0];
		endfunction

		function void note_date(bit [7:0] s, bit [7:0] m, bit [7:0] h, bit [7:0] d,
				bit [7:0] mo, bit [7:0] y);
			pending_secs.push_back(expected_secs(s, m, h, d, mo, y));
		endfunction

		function void check_seconds(logic [SecsW-1:0] got);
			logic [SecsW-1:0] want;
			if (pending_secs.size() == 0) begin
				$display("%0t: unexpected unix_seconds, expected none, actual %0d", $time, got);
				errors++;
			end else begin
				want = pending_secs.pop_front();
				if (got !== want) begin
					$display("%0t: unix_seconds mismatch, expected %0d, actual %0d",
						$time, want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  seconds_bcd;
	logic [7:0]  minutes_bcd;
	logic [7:0]  hours_bcd;
	logic [7:0]  date_bcd;
	logic [7:0]  month_bcd;
	logic [7:0]  year_bcd;
	logic        out_valid;
	logic        out_stall;
	logic [32:0] unix_seconds;

	bit          long_hold_req;
	bit          hold_active;
	int unsigned cycle_count;

	date_scoreboard sb = new();

	bcd_date_to_unix_seconds_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.seconds_bcd (seconds_bcd),
		.minutes_bcd (minutes_bcd),
		.hours_bcd   (hours_bcd),
		.date_bcd    (date_bcd),
		.month_bcd   (month_bcd),
		.year_bcd    (year_bcd),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.unix_seconds(unix_seconds)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_date(seconds_bcd, minutes_bcd, hours_bcd, date_bcd, month_bcd,
					year_bcd);
			if (out_valid && !out_stall)
				sb.check_seconds(unix_seconds);
		end
	end

	// Receiver: runs of random stall patterns, plus one long hold on request
	initial begin : receiver
		int unsigned mode;
		int unsigned span;
		int unsigned k;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_active   = 1'b1;
				for (k = 0; k < HoldCycles; k++) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
				hold_active = 1'b0;
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(1, 30);
				for (k = 0; k < span; k++) begin
					@(negedge clk);
					case (mode)
						0:       out_stall <= 1'b0;
						1:       out_stall <= ($urandom_range(0, 1) == 0);
						2:       out_stall <= ($urandom_range(0, 9) < 8);
						default: out_stall <= (k % 3 == 0);
					endcase
				end
			end
		end
	end

	function automatic bit [7:0] to_bcd(int unsigned v);
		return 8'((v / 10) * 16 + v % 10);
	endfunction

	task automatic send_date(input bit [7:0] s, input bit [7:0] m, input bit [7:0] h,
			input bit [7:0] d, input bit [7:0] mo, input bit [7:0] y);
		@(negedge clk);
		in_valid    <= 1'b1;
		seconds_bcd <= s;
		minutes_bcd <= m;
		hours_bcd   <= h;
		date_bcd    <= d;
		month_bcd   <= mo;
		year_bcd    <= y;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Idle cycles scramble the seconds and year bytes; the payload is don't-care while valid is low
	task automatic idle(input int unsigned n);
		repeat (n) begin
			@(negedge clk);
			in_valid    <= 1'b0;
			seconds_bcd <= 8'($urandom);
			year_bcd    <= 8'($urandom);
		end
	endtask

	// Mostly sane clock readings with random masked-off bits, else raw bytes
	task automatic send_random_date();
		bit [7:0] yr;
		if ($urandom_range(0, 9) < 7) begin
			yr = ($urandom_range(0, 7) == 0) ? 8'($urandom) : to_bcd($urandom_range(0, 99));
			send_date(to_bcd($urandom_range(0, 59)) | (8'($urandom) & 8'h80),
				to_bcd($urandom_range(0, 59)) | (8'($urandom) & 8'h80),
				to_bcd($urandom_range(0, 23)) | (8'($urandom) & 8'hC0),
				to_bcd($urandom_range(1, 31)) | (8'($urandom) & 8'hC0),
				to_bcd($urandom_range(1, 12)) | (8'($urandom) & 8'hE0),
				yr);
		end else begin
			send_date(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom));
		end
	endtask

	initial begin : stimulus
		int unsigned sent;
		int unsigned burst;
		int unsigned k;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		seconds_bcd = 8'h00;
		minutes_bcd = 8'h00;
		hours_bcd   = 8'h00;
		date_bcd    = 8'h00;
		month_bcd   = 8'h00;
		year_bcd    = 8'h00;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_date(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00);	// 2000-01-01
		send_date(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);	// month and date zero
		send_date(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_date(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99);
		send_date(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00);	// leap day
		send_date(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00);
		idle(3);
		send_date(8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h04);	// date zero after leap Feb
		send_date(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'hA0);	// 2100, not leap
		send_date(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'hA4);	// 2104, leap
		send_date(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h05);	// month saturates
		send_date(8'h00, 8'h00, 8'h00, 8'h01, 8'h1F, 8'h05);
		send_date(8'h7F, 8'h7F, 8'h3F, 8'h3F, 8'h0F, 8'h9F);	// bad nibbles
		send_date(8'h80, 8'h80, 8'hC0, 8'hC1, 8'hE1, 8'h00);	// masked bits set over 2000-01-01 00:00:00
		idle(1);
		send_date(8'h30, 8'h45, 8'h12, 8'h15, 8'h06, 8'h25);
		send_date(8'h01, 8'h01, 8'h01, 8'h28, 8'h02, 8'h01);
		send_date(8'h00, 8'h00, 8'h00, 8'h01, 8'h0A, 8'h10);
		send_date(8'hAA, 8'hBB, 8'h2C, 8'h1D, 8'h0E, 8'hFA);
		send_date(8'h55, 8'h55, 8'h15, 8'h15, 8'h15, 8'h55);

		// Long output hold while items keep coming, so the pipe backs up
		long_hold_req = 1'b1;
		wait (hold_active);
		sent = 0;
		for (k = 0; k < 40; k++) begin
			send_random_date();
			sent++;
		end

		while (sent < RandomItems) begin
			burst = $urandom_range(1, 24);
			for (k = 0; k < burst; k++) begin
				send_random_date();
				sent++;
			end
			if ($urandom_range(0, 1) == 0)
				idle($urandom_range(1, 8));
		end
		idle(1);

		while (sb.pending_secs.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_secs.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/bcdux_pkg.sv
src/bcdux_decode.sv
src/bcdux_days.sv
src/bcdux_secs.sv
src/bcd_date_to_unix_seconds_core.sv
sim/bcd_date_to_unix_seconds_core_tb.sv
